// ===== src/css_tok_pkg.sv =====
// ---------------------------------------------------------------------------
// css_tok_pkg
// Shared types, constants and the per-byte segmentation function of the
// stylesheet byte tokenizer.
// ---------------------------------------------------------------------------
package css_tok_pkg;

	localparam int BUFFER_CAPACITY = 1024;
	localparam int DEPTH_BITS      = 8;
	localparam int SEL_BITS        = 11;
	localparam int DECL_BITS       = 10;
	localparam int LIMIT_BITS      = 11;

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX     = '1;
	localparam logic [SEL_BITS-1:0]   SEL_MAX       = '1;
	localparam logic [DECL_BITS-1:0]  DECL_MAX      = '1;
	localparam logic [SEL_BITS-1:0]   SEL_EMIT_LIM  = SEL_BITS'(BUFFER_CAPACITY - 1);
	localparam logic [DECL_BITS-1:0]  DECL_EMIT_LIM = DECL_BITS'(BUFFER_CAPACITY - 1);
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET   = LIMIT_BITS'(1024);

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef enum logic [2:0] {
		EV_SEL_BYTE  = 3'd0,
		EV_BODY_OPEN = 3'd1,
		EV_DECL_BYTE = 3'd2,
		EV_DECL_END  = 3'd3,
		EV_RULE_END  = 3'd4
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [7:0] data;
		logic       skipped;
		logic       pending;
		logic       last;
	} event_t;

	typedef struct packed {
		logic                  in_comment;
		logic                  slash_pending;
		logic                  prev_star;
		logic                  in_at_rule;
		logic [DEPTH_BITS-1:0] at_depth;
		logic [DEPTH_BITS-1:0] body_depth;
		logic                  skipping;
		logic [SEL_BITS-1:0]   sel_count;
		logic [DECL_BITS-1:0]  decl_count;
	} tok_state_t;

	typedef struct packed {
		tok_state_t st;
		logic       ev_valid;
		event_t     ev;
	} handle_t;

	function automatic logic is_ws(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0C;
	endfunction

	// one byte through the segmenter, comment stripping already done
	function automatic handle_t tok_handle(tok_state_t s, logic [7:0] c,
			logic [LIMIT_BITS-1:0] limit);
		handle_t h;
		h.st       = s;
		h.ev_valid = 1'b0;
		h.ev       = '0;
		if (s.in_at_rule) begin
			if (c == CH_LBRACE) begin
				if (s.at_depth != DEPTH_MAX) h.st.at_depth = s.at_depth + 1'b1;
			end else if (c == CH_RBRACE) begin
				if (s.at_depth != '0) h.st.at_depth = s.at_depth - 1'b1;
				if (h.st.at_depth == '0) h.st.in_at_rule = 1'b0;
			end else if (c == CH_SEMI && s.at_depth == '0) begin
				h.st.in_at_rule = 1'b0;
			end
		end else if (s.body_depth == '0) begin
			if (s.sel_count == '0 && is_ws(c)) begin
				h.st = s;
			end else if (c == CH_AT && s.sel_count == '0) begin
				h.st.in_at_rule = 1'b1;
				h.st.at_depth   = '0;
			end else if (c == CH_LBRACE) begin
				h.st.body_depth = DEPTH_BITS'(1);
				h.st.decl_count = '0;
				h.st.skipping   = s.sel_count > limit;
				h.ev_valid      = 1'b1;
				h.ev.kind       = EV_BODY_OPEN;
				h.ev.skipped    = s.sel_count > limit;
			end else begin
				if (s.sel_count < SEL_EMIT_LIM) begin
					h.ev_valid = 1'b1;
					h.ev.kind  = EV_SEL_BYTE;
					h.ev.data  = c;
				end
				if (s.sel_count != SEL_MAX) h.st.sel_count = s.sel_count + 1'b1;
			end
		end else if (c == CH_LBRACE) begin
			if (s.body_depth != DEPTH_MAX) h.st.body_depth = s.body_depth + 1'b1;
		end else if (c == CH_RBRACE) begin
			h.st.body_depth = s.body_depth - 1'b1;
			if (s.body_depth == DEPTH_BITS'(1)) begin
				h.ev_valid      = 1'b1;
				h.ev.kind       = EV_RULE_END;
				h.ev.skipped    = s.skipping;
				h.ev.pending    = !s.skipping && s.decl_count != '0;
				h.st.sel_count  = '0;
				h.st.decl_count = '0;
				h.st.skipping   = 1'b0;
			end
		end else if (s.body_depth != DEPTH_BITS'(1) || s.skipping) begin
			h.st = s;
		end else if (c == CH_SEMI) begin
			if (s.decl_count != '0) begin
				h.ev_valid      = 1'b1;
				h.ev.kind       = EV_DECL_END;
				h.st.decl_count = '0;
			end
		end else begin
			if (s.decl_count < DECL_EMIT_LIM) begin
				h.ev_valid = 1'b1;
				h.ev.kind  = EV_DECL_BYTE;
				h.ev.data  = c;
			end
			if (s.decl_count != DECL_MAX) h.st.decl_count = s.decl_count + 1'b1;
		end
		return h;
	endfunction

endpackage

// ===== src/css_tok_step.sv =====
// ---------------------------------------------------------------------------
// css_tok_step
// Next-state and result logic for one input item: comment stripping, slash
// replay and up to two segmentation events.
// ---------------------------------------------------------------------------
module css_tok_step import css_tok_pkg::*; (
	input  tok_state_t            cur,
	input  logic                  operation,
	input  logic [7:0]            data_byte,
	input  logic [LIMIT_BITS-1:0] limit,
	output tok_state_t            nxt,
	output logic                  ev0_valid,
	output event_t                ev0,
	output logic                  ev1_valid,
	output event_t                ev1
);

	handle_t    h_slash;
	handle_t    h_byte;
	tok_state_t st_mid;
	logic       use_slash;
	logic       use_byte;
	logic       opens_comment;

	always_comb begin
		opens_comment = cur.slash_pending && data_byte == CH_STAR;
		use_slash = cur.slash_pending &&
			(operation == OP_FLUSH || (!cur.in_comment && !opens_comment));
		use_byte = operation == OP_DATA && !cur.in_comment && !opens_comment &&
			data_byte != CH_SLASH;

		h_slash = tok_handle(cur, CH_SLASH, limit);
		st_mid  = use_slash ? h_slash.st : cur;
		st_mid.slash_pending = 1'b0;
		h_byte  = tok_handle(st_mid, data_byte, limit);

		if (operation == OP_FLUSH) begin
			nxt = '0;
		end else if (cur.in_comment) begin
			nxt = cur;
			if (cur.prev_star && data_byte == CH_SLASH) begin
				nxt.in_comment = 1'b0;
				nxt.prev_star  = 1'b0;
			end else begin
				nxt.prev_star = data_byte == CH_STAR;
			end
		end else if (opens_comment) begin
			nxt = cur;
			nxt.slash_pending = 1'b0;
			nxt.in_comment    = 1'b1;
			nxt.prev_star     = 1'b0;
		end else if (data_byte == CH_SLASH) begin
			nxt = st_mid;
			nxt.slash_pending = 1'b1;
		end else begin
			nxt = h_byte.st;
		end

		// results in order: replayed slash first, then the byte itself
		ev0_valid = use_slash && h_slash.ev_valid;
		ev0       = h_slash.ev;
		ev1_valid = use_byte && h_byte.ev_valid;
		ev1       = h_byte.ev;
		ev0.last  = !ev1_valid;
		ev1.last  = 1'b1;
	end

endmodule

// ===== src/css_tok_outq.sv =====
// ---------------------------------------------------------------------------
// css_tok_outq
// Four-entry result queue taking up to two events per cycle and handing out
// one per transfer.
// ---------------------------------------------------------------------------
module css_tok_outq import css_tok_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push0,
	input  event_t ev0,
	input  logic   push1,
	input  event_t ev1,
	output logic   room,
	output logic   out_valid,
	input  logic   out_ready,
	output event_t head
);

	event_t     entry_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;
	logic [1:0] n_push;
	event_t     first;
	event_t     second;

	always_comb begin
		pop       = out_valid && out_ready;
		n_push    = 2'(push0) + 2'(push1);
		first     = push0 ? ev0 : ev1;
		second    = ev1;
		out_valid = count_q != '0;
		head      = entry_q[rd_ptr_q];
		// room for a full pair of results
		room      = count_q <= 3'd2;
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) entry_q[wr_ptr_q] <= first;
		if (n_push == 2'd2) entry_q[wr_ptr_q + 2'd1] <= second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + 3'(n_push) - 3'(pop);
		end
	end

endmodule

// ===== src/css_rule_byte_tokenizer.sv =====
// ---------------------------------------------------------------------------
// css_rule_byte_tokenizer
// Byte-serial stylesheet segmenter: strips comments, skips at-rules and
// emits selector, body, declaration and rule-end events.
// Results are registered in the result queue, whose head drives the output port.
// Throughput: one byte per cycle; an item with two results hands them to the output
// port one per transfer, and input stalls when the four-entry result queue has
// fewer than two free slots.
// Reset: all tokenizer state and the queue clear; skip limit returns to 1024.
// ---------------------------------------------------------------------------
module css_rule_byte_tokenizer import css_tok_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [LIMIT_BITS-1:0] cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [7:0]            data_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            event_kind,
	output logic [7:0]            event_byte,
	output logic                  rule_skipped,
	output logic                  declaration_pending,
	output logic                  last_of_run
);

	tok_state_t            state_q;
	tok_state_t            state_nxt;
	logic [LIMIT_BITS-1:0] limit_q;
	logic                  accept;
	logic                  ev0_valid;
	logic                  ev1_valid;
	event_t                ev0;
	event_t                ev1;
	event_t                head;

	assign accept = in_valid && in_ready;

	css_tok_step u_step (
		.cur       (state_q),
		.operation (operation),
		.data_byte (data_byte),
		.limit     (limit_q),
		.nxt       (state_nxt),
		.ev0_valid (ev0_valid),
		.ev0       (ev0),
		.ev1_valid (ev1_valid),
		.ev1       (ev1)
	);

	css_tok_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (accept && ev0_valid),
		.ev0       (ev0),
		.push1     (accept && ev1_valid),
		.ev1       (ev1),
		.room      (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			limit_q <= LIMIT_RESET;
		end else begin
			if (accept) state_q <= state_nxt;
			if (cfg_wr_en) limit_q <= cfg_wr_data;
		end
	end

	assign event_kind          = head.kind;
	assign event_byte          = head.data;
	assign rule_skipped        = head.skipped;
	assign declaration_pending = head.pending;
	assign last_of_run         = head.last;

endmodule

// ===== tb/sv/css_rule_byte_tokenizer_chk.sv =====
// ---------------------------------------------------------------------------
// css_rule_byte_tokenizer_chk
// Watches the byte and event channels of the stylesheet tokenizer, predicts
// the events of every accepted byte from its own copy of the segmenter
// state and skip limit, and compares each event transfer field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module css_rule_byte_tokenizer_chk import css_tok_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [LIMIT_BITS-1:0] cfg_wr_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  operation,
	input  logic [7:0]            data_byte,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [2:0]            event_kind,
	input  logic [7:0]            event_byte,
	input  logic                  rule_skipped,
	input  logic                  declaration_pending,
	input  logic                  last_of_run,
	output int                    fail_count,
	output int                    outstanding
);

	localparam int APPEND_LIM = BUFFER_CAPACITY - 1;

	typedef struct packed {
		ev_kind_t   kind;
		logic [7:0] ch;
		logic       skipped;
		logic       pending;
		logic       last;
	} tok_event_t;

	logic                  in_cmt, slash_held, star_seen, in_at, skip_rule;
	logic [DEPTH_BITS-1:0] at_lvl, body_lvl;
	logic [SEL_BITS-1:0]   sel_len;
	logic [DECL_BITS-1:0]  decl_len;
	logic [LIMIT_BITS-1:0] skip_limit;

	tok_event_t events_due[$];
	tok_event_t byte_events[$];
	int         errors;

	function automatic logic blank_char(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0C;
	endfunction

	task automatic clear_tokenizer();
		in_cmt     = 1'b0;
		slash_held = 1'b0;
		star_seen  = 1'b0;
		in_at      = 1'b0;
		at_lvl     = '0;
		body_lvl   = '0;
		skip_rule  = 1'b0;
		sel_len    = '0;
		decl_len   = '0;
	endtask

	task automatic note_event(ev_kind_t k, logic [7:0] c, logic s, logic p);
		tok_event_t e;
		e.kind    = k;
		e.ch      = c;
		e.skipped = s;
		e.pending = p;
		e.last    = 1'b0;
		byte_events = {byte_events, e};
	endtask

	// one byte after comment stripping
	task automatic segment_byte(logic [7:0] c);
		if (in_at) begin
			if (c == CH_LBRACE) begin
				if (at_lvl != '1) at_lvl++;
			end else if (c == CH_RBRACE) begin
				if (at_lvl != '0) at_lvl--;
				if (at_lvl == '0) in_at = 1'b0;
			end else if (c == CH_SEMI && at_lvl == '0) begin
				in_at = 1'b0;
			end
		end else if (body_lvl == '0) begin
			if (sel_len == '0 && blank_char(c)) begin
				// leading whitespace is dropped
			end else if (c == CH_AT && sel_len == '0) begin
				in_at  = 1'b1;
				at_lvl = '0;
			end else if (c == CH_LBRACE) begin
				body_lvl  = DEPTH_BITS'(1);
				decl_len  = '0;
				skip_rule = sel_len > skip_limit;
				note_event(EV_BODY_OPEN, 8'h00, skip_rule, 1'b0);
			end else begin
				if (sel_len < APPEND_LIM) note_event(EV_SEL_BYTE, c, 1'b0, 1'b0);
				if (sel_len != '1) sel_len++;
			end
		end else if (c == CH_LBRACE) begin
			if (body_lvl != '1) body_lvl++;
		end else if (c == CH_RBRACE) begin
			body_lvl--;
			if (body_lvl == '0) begin
				note_event(EV_RULE_END, 8'h00, skip_rule, !skip_rule && decl_len != '0);
				sel_len   = '0;
				decl_len  = '0;
				skip_rule = 1'b0;
			end
		end else if (body_lvl != DEPTH_BITS'(1) || skip_rule) begin
			// nested or suppressed body bytes
		end else if (c == CH_SEMI) begin
			if (decl_len != '0) begin
				note_event(EV_DECL_END, 8'h00, 1'b0, 1'b0);
				decl_len = '0;
			end
		end else begin
			if (decl_len < APPEND_LIM) note_event(EV_DECL_BYTE, c, 1'b0, 1'b0);
			if (decl_len != '1) decl_len++;
		end
	endtask

	task automatic predict_item(logic op, logic [7:0] c);
		logic opened;
		opened = 1'b0;
		byte_events.delete();
		if (op == OP_FLUSH) begin
			if (slash_held) segment_byte(CH_SLASH);
			clear_tokenizer();
		end else if (in_cmt) begin
			if (star_seen && c == CH_SLASH) begin
				in_cmt    = 1'b0;
				star_seen = 1'b0;
			end else begin
				star_seen = (c == CH_STAR);
			end
		end else begin
			// a held slash is either a comment opener or replayed as data
			if (slash_held) begin
				slash_held = 1'b0;
				if (c == CH_STAR) begin
					in_cmt    = 1'b1;
					star_seen = 1'b0;
					opened    = 1'b1;
				end else begin
					segment_byte(CH_SLASH);
				end
			end
			if (!opened) begin
				if (c == CH_SLASH) slash_held = 1'b1;
				else segment_byte(c);
			end
		end
		if (byte_events.size() > 0) byte_events[byte_events.size() - 1].last = 1'b1;
		foreach (byte_events[i]) events_due = {events_due, byte_events[i]};
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		tok_event_t want;
		if (!arst_n) begin
			clear_tokenizer();
			skip_limit = LIMIT_RESET;
			events_due.delete();
			errors = 0;
		end else begin
			if (in_valid && in_ready) predict_item(operation, data_byte);
			if (out_valid && out_ready) begin
				if (events_due.size() == 0) begin
					errors++;
					$error("unexpected event transfer: event_kind %0d event_byte %02h",
						event_kind, event_byte);
				end else begin
					want = events_due.pop_front();
					if (event_kind !== want.kind) begin
						errors++;
						$error("event_kind mismatch: expected %0d, actual %0d",
							want.kind, event_kind);
					end
					if (event_byte !== want.ch) begin
						errors++;
						$error("event_byte mismatch: expected %02h, actual %02h",
							want.ch, event_byte);
					end
					if (rule_skipped !== want.skipped) begin
						errors++;
						$error("rule_skipped mismatch: expected %0b, actual %0b",
							want.skipped, rule_skipped);
					end
					if (declaration_pending !== want.pending) begin
						errors++;
						$error("declaration_pending mismatch: expected %0b, actual %0b",
							want.pending, declaration_pending);
					end
					if (last_of_run !== want.last) begin
						errors++;
						$error("last_of_run mismatch: expected %0b, actual %0b",
							want.last, last_of_run);
					end
				end
			end
			if (cfg_wr_en) skip_limit = cfg_wr_data;
		end
		fail_count  <= errors;
		outstanding <= events_due.size();
	end

endmodule

// ===== tb/sv/css_rule_byte_tokenizer_tb.sv =====
// ---------------------------------------------------------------------------
// css_rule_byte_tokenizer_tb
// Stimulus and verdict for the stylesheet tokenizer: directed byte strings
// for whitespace, slashes, comments, at-rules and nested bodies, then random
// rules, at-rules, comments and noise under several skip limits, and a long
// run that reaches the body depth saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module css_rule_byte_tokenizer_tb;
	import css_tok_pkg::*;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [LIMIT_BITS-1:0] cfg_wr_data = '0;
	logic                  in_valid    = 1'b0;
	logic                  operation   = OP_DATA;
	logic [7:0]            data_byte   = '0;
	logic                  out_ready   = 1'b0;
	logic                  in_ready, out_valid;
	logic [2:0]            event_kind;
	logic [7:0]            event_byte;
	logic                  rule_skipped, declaration_pending, last_of_run;
	int                    fails, pending;

	logic                  no_idle = 1'b0;
	int                    ready_hold = 0;
	int                    ready_roll;
	int                    phase_bytes;
	logic [LIMIT_BITS-1:0] cur_limit = LIMIT_RESET;
	logic [LIMIT_BITS-1:0] phase_limit[6];

	css_rule_byte_tokenizer u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_wr_data         (cfg_wr_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.operation           (operation),
		.data_byte           (data_byte),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.event_kind          (event_kind),
		.event_byte          (event_byte),
		.rule_skipped        (rule_skipped),
		.declaration_pending (declaration_pending),
		.last_of_run         (last_of_run)
	);

	css_rule_byte_tokenizer_chk u_chk (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_wr_data         (cfg_wr_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.operation           (operation),
		.data_byte           (data_byte),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.event_kind          (event_kind),
		.event_byte          (event_byte),
		.rule_skipped        (rule_skipped),
		.declaration_pending (declaration_pending),
		.last_of_run         (last_of_run),
		.fail_count          (fails),
		.outstanding         (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// event side back-pressure
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (no_idle || ready_roll < 60) begin
				out_ready <= 1'b1;
				ready_hold = $urandom_range(0, 10);
			end else if (ready_roll < 92) begin
				out_ready <= 1'b0;
				ready_hold = $urandom_range(0, 2);
			end else begin
				out_ready <= 1'b0;
				ready_hold = $urandom_range(4, 30);
			end
		end
	end

	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 65) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// content byte that never opens or closes anything
	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == CH_LBRACE || c == CH_RBRACE || c == CH_SEMI || c == CH_AT
			|| c == CH_SLASH);
		return c;
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 9))
			0: return CH_LBRACE;
			1: return CH_RBRACE;
			2: return CH_SEMI;
			3: return CH_AT;
			4: return CH_SLASH;
			5: return CH_STAR;
			6: return 8'h20;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] blank_pick();
		case ($urandom_range(0, 4))
			0: return 8'h20;
			1: return 8'h09;
			2: return 8'h0A;
			3: return 8'h0D;
			default: return 8'h0C;
		endcase
	endfunction

	task automatic send_item(logic op, logic [7:0] c);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		data_byte <= c;
		do @(posedge clk); while (in_ready !== 1'b1);
		phase_bytes++;
	endtask

	task automatic put_byte(logic [7:0] c);
		send_item(OP_DATA, c);
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endtask

	task automatic put_repeat(logic [7:0] c, int n);
		repeat (n) put_byte(c);
	endtask

	task automatic flush_stream();
		send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
	endtask

	// wait for every expected event, then let in-flight bytes settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limit(logic [LIMIT_BITS-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		cur_limit = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_rule();
		int n;
		int k;
		if ($urandom_range(0, 3) == 0) put_byte(blank_pick());
		if ($urandom_range(0, 4) == 0 && cur_limit < 40) n = cur_limit + $urandom_range(0, 1);
		else n = $urandom_range(0, 12);
		repeat (n) put_byte(plain_byte());
		if ($urandom_range(0, 5) == 0) put_text("/*c*/");
		put_byte(CH_LBRACE);
		k = $urandom_range(0, 3);
		repeat (k) begin
			repeat ($urandom_range(0, 8)) put_byte(plain_byte());
			if ($urandom_range(0, 5) == 0) put_text("{x;}");
			if ($urandom_range(0, 4) != 0) put_byte(CH_SEMI);
		end
		if ($urandom_range(0, 3) == 0) put_byte(CH_SEMI);
		put_byte(CH_RBRACE);
	endtask

	task automatic random_unit();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			random_rule();
		end else if (roll < 67) begin
			put_byte(CH_AT);
			repeat ($urandom_range(0, 5)) put_byte(plain_byte());
			case ($urandom_range(0, 2))
				0: put_byte(CH_SEMI);
				1: put_text("{a{b;}}");
				default: put_byte(CH_RBRACE);
			endcase
		end else if (roll < 75) begin
			put_text("/*");
			repeat ($urandom_range(0, 6)) put_byte(noise_byte());
			put_text("*/");
		end else if (roll < 83) begin
			put_byte(CH_SLASH);
			put_byte(plain_byte());
		end else if (roll < 93) begin
			repeat ($urandom_range(1, 6)) put_byte(noise_byte());
		end else begin
			flush_stream();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: whitespace, byte extremes, slash replay, nesting,
		// empty declaration, at-rules, stray close, comment, flushes
		put_byte(8'h0C);
		put_byte(8'h0D);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_text("/x{;c{z};d}");
		put_text("@{}@}");
		put_text("/*q*/");
		put_text("e{/");
		flush_stream();
		put_byte(CH_SLASH);
		flush_stream();
		drain();

		phase_limit[0] = '0;
		phase_limit[1] = '1;
		phase_limit[2] = LIMIT_BITS'(5);
		phase_limit[3] = LIMIT_BITS'($urandom_range(6, 2046));
		phase_limit[4] = LIMIT_RESET;
		phase_limit[5] = LIMIT_BITS'(1);
		for (int p = 0; p < 6; p++) begin
			set_limit(phase_limit[p]);
			no_idle = (p == 3);
			if (p == 0) put_text("a{b;}");
			phase_bytes = 0;
			while (phase_bytes < 70) begin
				if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
				if ($urandom_range(0, 39) == 0) drain();
				random_unit();
			end
			drain();
		end

		// long run: body depth saturates, so the byte after it stays nested
		no_idle = 1'b1;
		put_text("x{");
		put_repeat(CH_LBRACE, 256);
		put_byte(plain_byte());
		flush_stream();
		drain();

		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
